[rtl/cse_pkg.sv]
// Package with type codes, widths and the reference sub-entity tables of the cell enumerator.
package cse_pkg;

    localparam int VID_W  = 24;
    localparam int NUM_V  = 8;
    localparam int DATA_W = VID_W * NUM_V;

    // Cell and sub-entity type codes.
    localparam logic [2:0] CT_POINT = 3'd0;
    localparam logic [2:0] CT_SEG   = 3'd1;
    localparam logic [2:0] CT_TRI   = 3'd2;
    localparam logic [2:0] CT_QUAD  = 3'd3;
    localparam logic [2:0] CT_TET   = 3'd4;
    localparam logic [2:0] CT_HEX   = 3'd5;
    localparam logic [2:0] CT_WEDGE = 3'd6;

    typedef logic [NUM_V-1:0][VID_W-1:0] vid_vec_t;

    typedef struct packed {
        logic [2:0]       sub_type;
        logic [2:0]       nv;
        logic [3:0][2:0]  lv;
    } sub_entry_t;

    function automatic logic [1:0] cell_dim(input logic [2:0] ct);
        logic [1:0] d;
        case (ct)
            CT_POINT: d = 2'd0;
            CT_SEG:   d = 2'd1;
            CT_TRI:   d = 2'd2;
            CT_QUAD:  d = 2'd2;
            CT_TET:   d = 2'd3;
            CT_HEX:   d = 2'd3;
            CT_WEDGE: d = 2'd3;
            default:  d = 2'd0;
        endcase
        return d;
    endfunction

    function automatic logic [3:0] cell_nv(input logic [2:0] ct);
        logic [3:0] n;
        case (ct)
            CT_POINT: n = 4'd1;
            CT_SEG:   n = 4'd2;
            CT_TRI:   n = 4'd3;
            CT_QUAD:  n = 4'd4;
            CT_TET:   n = 4'd4;
            CT_HEX:   n = 4'd8;
            CT_WEDGE: n = 4'd6;
            default:  n = 4'd0;
        endcase
        return n;
    endfunction

    // First table row of the edges (dim 1) or faces (dim 2) of a cell.
    function automatic logic [5:0] mid_start(input logic [2:0] ct, input logic [1:0] dim);
        logic [5:0] s;
        s = 6'd0;
        case (ct)
            CT_QUAD:  s = 6'd3;
            CT_TET:   s = (dim == 2'd1) ? 6'd7  : 6'd13;
            CT_HEX:   s = (dim == 2'd1) ? 6'd17 : 6'd29;
            CT_WEDGE: s = (dim == 2'd1) ? 6'd35 : 6'd44;
            default:  s = 6'd0;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] mid_count(input logic [2:0] ct, input logic [1:0] dim);
        logic [3:0] c;
        c = 4'd0;
        case (ct)
            CT_TRI:   c = (dim == 2'd1) ? 4'd3 : 4'd0;
            CT_QUAD:  c = (dim == 2'd1) ? 4'd4 : 4'd0;
            CT_TET:   c = (dim == 2'd1) ? 4'd6 : 4'd4;
            CT_HEX:   c = (dim == 2'd1) ? 4'd12 : 4'd6;
            CT_WEDGE: c = (dim == 2'd1) ? 4'd9 : 4'd5;
            default:  c = 4'd0;
        endcase
        return c;
    endfunction

    function automatic sub_entry_t mk(input logic [2:0] st, input logic [2:0] a,
                                      input logic [2:0] b, input logic [2:0] c,
                                      input logic [2:0] d);
        sub_entry_t e;
        e.sub_type = st;
        e.nv       = (st == CT_SEG) ? 3'd2 : ((st == CT_TRI) ? 3'd3 : 3'd4);
        e.lv       = {d, c, b, a};
        return e;
    endfunction

    // Edges of the 2-D and 3-D cells and faces of the 3-D cells, in reference order and orientation.
    function automatic sub_entry_t sub_lookup(input logic [5:0] row);
        sub_entry_t e;
        case (row)
            // triangle edges
            6'd0:  e = mk(CT_SEG, 3'd0, 3'd1, 3'd0, 3'd0);
            6'd1:  e = mk(CT_SEG, 3'd1, 3'd2, 3'd0, 3'd0);
            6'd2:  e = mk(CT_SEG, 3'd2, 3'd0, 3'd0, 3'd0);
            // quadrilateral edges
            6'd3:  e = mk(CT_SEG, 3'd0, 3'd1, 3'd0, 3'd0);
            6'd4:  e = mk(CT_SEG, 3'd1, 3'd2, 3'd0, 3'd0);
            6'd5:  e = mk(CT_SEG, 3'd2, 3'd3, 3'd0, 3'd0);
            6'd6:  e = mk(CT_SEG, 3'd3, 3'd0, 3'd0, 3'd0);
            // tetrahedron edges
            6'd7:  e = mk(CT_SEG, 3'd0, 3'd1, 3'd0, 3'd0);
            6'd8:  e = mk(CT_SEG, 3'd0, 3'd2, 3'd0, 3'd0);
            6'd9:  e = mk(CT_SEG, 3'd0, 3'd3, 3'd0, 3'd0);
            6'd10: e = mk(CT_SEG, 3'd1, 3'd2, 3'd0, 3'd0);
            6'd11: e = mk(CT_SEG, 3'd1, 3'd3, 3'd0, 3'd0);
            6'd12: e = mk(CT_SEG, 3'd2, 3'd3, 3'd0, 3'd0);
            // tetrahedron faces
            6'd13: e = mk(CT_TRI, 3'd1, 3'd2, 3'd3, 3'd0);
            6'd14: e = mk(CT_TRI, 3'd0, 3'd3, 3'd2, 3'd0);
            6'd15: e = mk(CT_TRI, 3'd0, 3'd1, 3'd3, 3'd0);
            6'd16: e = mk(CT_TRI, 3'd0, 3'd2, 3'd1, 3'd0);
            // hexahedron edges
            6'd17: e = mk(CT_SEG, 3'd0, 3'd1, 3'd0, 3'd0);
            6'd18: e = mk(CT_SEG, 3'd1, 3'd2, 3'd0, 3'd0);
            6'd19: e = mk(CT_SEG, 3'd2, 3'd3, 3'd0, 3'd0);
            6'd20: e = mk(CT_SEG, 3'd3, 3'd0, 3'd0, 3'd0);
            6'd21: e = mk(CT_SEG, 3'd4, 3'd5, 3'd0, 3'd0);
            6'd22: e = mk(CT_SEG, 3'd5, 3'd6, 3'd0, 3'd0);
            6'd23: e = mk(CT_SEG, 3'd6, 3'd7, 3'd0, 3'd0);
            6'd24: e = mk(CT_SEG, 3'd7, 3'd4, 3'd0, 3'd0);
            6'd25: e = mk(CT_SEG, 3'd0, 3'd4, 3'd0, 3'd0);
            6'd26: e = mk(CT_SEG, 3'd1, 3'd5, 3'd0, 3'd0);
            6'd27: e = mk(CT_SEG, 3'd2, 3'd6, 3'd0, 3'd0);
            6'd28: e = mk(CT_SEG, 3'd3, 3'd7, 3'd0, 3'd0);
            // hexahedron faces
            6'd29: e = mk(CT_QUAD, 3'd0, 3'd1, 3'd2, 3'd3);
            6'd30: e = mk(CT_QUAD, 3'd0, 3'd1, 3'd5, 3'd4);
            6'd31: e = mk(CT_QUAD, 3'd1, 3'd2, 3'd6, 3'd5);
            6'd32: e = mk(CT_QUAD, 3'd2, 3'd3, 3'd7, 3'd6);
            6'd33: e = mk(CT_QUAD, 3'd3, 3'd0, 3'd4, 3'd7);
            6'd34: e = mk(CT_QUAD, 3'd4, 3'd5, 3'd6, 3'd7);
            // wedge edges
            6'd35: e = mk(CT_SEG, 3'd0, 3'd1, 3'd0, 3'd0);
            6'd36: e = mk(CT_SEG, 3'd1, 3'd2, 3'd0, 3'd0);
            6'd37: e = mk(CT_SEG, 3'd2, 3'd0, 3'd0, 3'd0);
            6'd38: e = mk(CT_SEG, 3'd3, 3'd4, 3'd0, 3'd0);
            6'd39: e = mk(CT_SEG, 3'd4, 3'd5, 3'd0, 3'd0);
            6'd40: e = mk(CT_SEG, 3'd5, 3'd3, 3'd0, 3'd0);
            6'd41: e = mk(CT_SEG, 3'd0, 3'd3, 3'd0, 3'd0);
            6'd42: e = mk(CT_SEG, 3'd1, 3'd4, 3'd0, 3'd0);
            6'd43: e = mk(CT_SEG, 3'd2, 3'd5, 3'd0, 3'd0);
            // wedge faces
            6'd44: e = mk(CT_TRI,  3'd0, 3'd1, 3'd2, 3'd0);
            6'd45: e = mk(CT_QUAD, 3'd0, 3'd1, 3'd4, 3'd3);
            6'd46: e = mk(CT_QUAD, 3'd1, 3'd2, 3'd5, 3'd4);
            6'd47: e = mk(CT_QUAD, 3'd2, 3'd0, 3'd3, 3'd5);
            6'd48: e = mk(CT_TRI,  3'd3, 3'd5, 3'd4, 3'd0);
            default: e = mk(CT_SEG, 3'd0, 3'd0, 3'd0, 3'd0);
        endcase
        return e;
    endfunction

endpackage

[rtl/cell_subentity_enumerator_top.sv]
// Top level of the cell sub-entity enumerator: cell register, index counter and result register.
//
//  Channel | Direction | Handshake           | Content
//  s_      | in        | s_tvalid / s_tready | one cell: type, target dimension, eight vertex ids
//  m_      | out       | m_tvalid / m_tready | one sub-entity per transfer, m_tlast on a cell's final one
//
// A cell produces 1 to 12 results (12 for the edges of a hexahedron), one per cycle while
// m_tready does not stall, and it holds the cell register until its final result moves out.
// The next cell is taken in the same cycle as the final result of the current one moves
// into the result register, so single-result cells stream at one per cycle without stalls.
// A stall on m_tready holds the result register and, behind it, the cell register.
// Reset clears the valid flags and the index counter; no request is lost or invented.
module cell_subentity_enumerator_top
    import cse_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // vert0 .. vert7, 24 bits each
    input  logic [4:0]        s_tuser,   // cell_type [2:0], target_dim [4:3]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // out_vert0 .. out_vert7, 24 bits each
    output logic [3:0]        m_tuser,   // sub_type [2:0], dim_error [3]
    output logic              m_tlast    // last_of_run
);

    // Cell register.
    logic             cell_valid_reg, cell_valid_next;
    logic [2:0]       type_reg;
    logic [1:0]       dim_reg;
    vid_vec_t         vid_reg;
    logic [3:0]       idx_reg, idx_next;

    // Result register.
    logic             m_valid_reg, m_valid_next;
    vid_vec_t         m_vid_reg;
    logic [2:0]       m_type_reg;
    logic             m_err_reg;
    logic             m_last_reg;

    logic             accept;
    logic             out_load;
    logic             item_done;

    logic [1:0]       cdim;
    logic [3:0]       nv;
    logic             err;
    logic [3:0]       count;
    logic             res_last;
    logic [5:0]       row;
    sub_entry_t       ent;
    logic [2:0]       res_type;
    vid_vec_t         res_vid;

    always_comb begin
        cdim  = cell_dim(type_reg);
        nv    = cell_nv(type_reg);
        // Type code 7 has no dimension of its own and is reported like a dimension error.
        err   = (type_reg > CT_WEDGE) || (dim_reg > cdim);
        row   = mid_start(type_reg, dim_reg) + {2'b00, idx_reg};
        ent   = sub_lookup(row);
        res_type = CT_POINT;
        res_vid  = '0;
        if (err) begin
            count = 4'd1;
        end else if (dim_reg == 2'd0) begin
            count = nv;
            res_vid[0] = vid_reg[idx_reg[2:0]];
        end else if (dim_reg == cdim) begin
            count    = 4'd1;
            res_type = type_reg;
            for (int k = 0; k < NUM_V; k++) begin
                if (4'(k) < nv) begin
                    res_vid[k] = vid_reg[k];
                end
            end
        end else begin
            count    = mid_count(type_reg, dim_reg);
            res_type = ent.sub_type;
            for (int j = 0; j < 4; j++) begin
                if (3'(j) < ent.nv) begin
                    res_vid[j] = vid_reg[ent.lv[j]];
                end
            end
        end
        res_last = (idx_reg == count - 4'd1);
    end

    assign out_load  = cell_valid_reg && (!m_valid_reg || m_tready);
    assign item_done = out_load && res_last;
    assign s_tready  = !cell_valid_reg || item_done;
    assign accept    = s_tvalid && s_tready;

    always_comb begin
        cell_valid_next = cell_valid_reg;
        idx_next        = idx_reg;
        if (accept) begin
            cell_valid_next = 1'b1;
            idx_next        = 4'd0;
        end else if (item_done) begin
            cell_valid_next = 1'b0;
        end else if (out_load) begin
            idx_next = idx_reg + 4'd1;
        end
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_valid_reg <= 1'b0;
            idx_reg        <= 4'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            cell_valid_reg <= cell_valid_next;
            idx_reg        <= idx_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            type_reg <= s_tuser[2:0];
            dim_reg  <= s_tuser[4:3];
            vid_reg  <= s_tdata;
        end
        if (out_load) begin
            m_vid_reg  <= res_vid;
            m_type_reg <= res_type;
            m_err_reg  <= err;
            m_last_reg <= res_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_vid_reg;
    assign m_tuser  = {m_err_reg, m_type_reg};
    assign m_tlast  = m_last_reg;

    // An error result is always the only, and so the last, result of its cell.
    a_err_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[3] |-> m_tlast && (m_tdata == '0) && (m_tuser[2:0] == CT_POINT))
        else $error("error result not final or not cleared");

    // The index never runs past the number of results of the held cell.
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cell_valid_reg |-> idx_reg < count)
        else $error("sub-entity index out of range");

    // A new cell is never taken while the held one still has results to give.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        cell_valid_reg && !item_done |-> !s_tready)
        else $error("cell register overrun");

    // After a non-final result moves out, the same cell stays and the index advances.
    a_idx_step: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && !res_last |=> cell_valid_reg && (idx_reg == $past(idx_reg) + 4'd1))
        else $error("index did not advance");

endmodule

[tb/cell_subentity_enumerator_top_tb.sv]
// Self-checking testbench for the cell sub-entity enumerator, with its own prediction model.
module cell_subentity_enumerator_top_tb
    import cse_pkg::*;
();

    localparam logic [2:0] CT_UNKNOWN  = 3'd7;
    localparam int         STALL_LIMIT = 2000;
    localparam int         DRAIN_WAIT  = 16;

    typedef struct packed {
        logic [2:0] sub_type;
        vid_vec_t   verts;
        logic       last;
        logic       err;
    } subentity_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata  = '0;
    logic [4:0]        s_tuser  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic [3:0]        m_tuser;
    logic              m_tlast;

    subentity_t expected_subentities[$];
    int         mismatches   = 0;
    int         idle_cycles  = 0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;

    cell_subentity_enumerator_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic queue_expected(input subentity_t e);
        expected_subentities.insert(expected_subentities.size(), e);
    endtask

    // Works out every sub-entity a cell request yields and queues them in output order.
    task automatic predict_subentities(input logic [2:0] ct, input logic [1:0] dim,
                                       input vid_vec_t v);
        string      cell_dims, cell_nverts, lv;
        int         cdim, nv, stride, count, n;
        subentity_t e;
        cell_dims   = "0122333";
        cell_nverts = "1234486";
        lv          = "";
        stride      = 2;
        cdim        = (ct > CT_WEDGE) ? 0 : int'(cell_dims[ct]) - 48;
        nv          = (ct > CT_WEDGE) ? 0 : int'(cell_nverts[ct]) - 48;
        if (ct > CT_WEDGE || dim > cdim) begin
            e      = '0;
            e.last = 1'b1;
            e.err  = 1'b1;
            queue_expected(e);
        end else if (dim == 2'd0) begin
            for (int k = 0; k < nv; k++) begin
                e          = '0;
                e.sub_type = CT_POINT;
                e.verts[0] = v[k];
                e.last     = (k == nv - 1);
                queue_expected(e);
            end
        end else if (dim == cdim) begin
            e          = '0;
            e.sub_type = ct;
            for (int k = 0; k < nv; k++)
                e.verts[k] = v[k];
            e.last     = 1'b1;
            queue_expected(e);
        end else begin
            // Edge lists hold two local vertices per entity, face lists four
            // (a triangle face leaves its fourth slot unused).
            case (ct)
                CT_TRI:  lv = "011220";
                CT_QUAD: lv = "01122330";
                CT_TET: begin
                    if (dim == 2'd1) begin
                        lv = "010203121323";
                    end else begin
                        lv     = "1230032001300210";
                        stride = 4;
                    end
                end
                CT_HEX: begin
                    if (dim == 2'd1) begin
                        lv = "011223304556677404152637";
                    end else begin
                        lv     = "012301541265237630474567";
                        stride = 4;
                    end
                end
                default: begin
                    if (dim == 2'd1) begin
                        lv = "011220344553031425";
                    end else begin
                        lv     = "01200143125420353540";
                        stride = 4;
                    end
                end
            endcase
            count = lv.len() / stride;
            for (int k = 0; k < count; k++) begin
                e = '0;
                if (stride == 2)
                    e.sub_type = CT_SEG;
                else if (ct == CT_TET)
                    e.sub_type = CT_TRI;
                else if (ct == CT_HEX)
                    e.sub_type = CT_QUAD;
                else
                    e.sub_type = (k == 0 || k == 4) ? CT_TRI : CT_QUAD;
                n = (e.sub_type == CT_SEG) ? 2 : ((e.sub_type == CT_TRI) ? 3 : 4);
                for (int j = 0; j < n; j++)
                    e.verts[j] = v[int'(lv[k * stride + j]) - 48];
                e.last = (k == count - 1);
                queue_expected(e);
            end
        end
    endtask

    task automatic report_mismatch(input string field, input logic [23:0] exp_val,
                                   input logic [23:0] got_val);
        $display("%0t: mismatch in %s: expected %h, got %h", $realtime, field, exp_val, got_val);
        mismatches++;
    endtask

    task automatic send_cell(input logic [2:0] ct, input logic [1:0] dim, input vid_vec_t v);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tuser  <= {dim, ct};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predict_subentities(ct, dim, v);
    endtask

    task automatic send_random_cells(input int count);
        logic [2:0] ct;
        logic [1:0] dim;
        vid_vec_t   v;
        int         cdim;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 10) begin
                // Unrestricted codes, which can give too-high dimensions and the unknown type.
                ct  = 3'($urandom_range(7));
                dim = 2'($urandom_range(3));
            end else begin
                ct   = 3'($urandom_range(6));
                cdim = (ct == CT_POINT) ? 0 : (ct == CT_SEG) ? 1 : (ct <= CT_QUAD) ? 2 : 3;
                dim  = 2'($urandom_range(cdim));
            end
            for (int k = 0; k < NUM_V; k++) begin
                case ($urandom_range(15))
                    0:       v[k] = '0;
                    1:       v[k] = '1;
                    default: v[k] = 24'($urandom());
                endcase
            end
            send_cell(ct, dim, v);
        end
    endtask

    // Every valid type and dimension pair with extreme vertex ids, then four error cases.
    task automatic test_directed();
        vid_vec_t v;
        int       idx;
        idx = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int t = CT_POINT; t <= CT_WEDGE; t++) begin
            for (int d = 0; d < 4; d++) begin
                if ((t == CT_POINT && d > 0) || (t == CT_SEG && d > 1) ||
                    ((t == CT_TRI || t == CT_QUAD) && d > 2))
                    continue;
                for (int k = 0; k < NUM_V; k++)
                    v[k] = idx[0] ? 24'hFFFFFF - 24'(k) : 24'(k);
                send_cell(t[2:0], d[1:0], v);
                idx++;
            end
        end
        for (int k = 0; k < NUM_V; k++)
            v[k] = 24'hA5A5A5 ^ 24'(k);
        send_cell(CT_POINT, 2'd3, v);
        send_cell(CT_TRI, 2'd3, v);
        send_cell(CT_UNKNOWN, 2'd0, v);
        send_cell(CT_UNKNOWN, 2'd3, '1);
    endtask

    task automatic test_back_to_back();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random_cells(96);
    endtask

    task automatic test_sender_gaps();
        send_idle_pct  = 68;
        recv_stall_pct = 0;
        send_random_cells(96);
    endtask

    task automatic test_receiver_stalls();
        send_idle_pct  = 0;
        recv_stall_pct = 68;
        send_random_cells(96);
    endtask

    task automatic test_both_sides_idle();
        send_idle_pct  = 14;
        recv_stall_pct = 14;
        send_random_cells(96);
    endtask

    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge aclk) begin
        subentity_t exp_e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_subentities.size() == 0) begin
                report_mismatch("output with no request pending", 24'd0, 24'd0);
            end else begin
                exp_e = expected_subentities.pop_front();
                if (m_tuser[2:0] !== exp_e.sub_type)
                    report_mismatch("sub_type", 24'(exp_e.sub_type), 24'(m_tuser[2:0]));
                for (int k = 0; k < NUM_V; k++) begin
                    if (m_tdata[k*VID_W +: VID_W] !== exp_e.verts[k])
                        report_mismatch($sformatf("out_vert%0d", k), exp_e.verts[k],
                                        m_tdata[k*VID_W +: VID_W]);
                end
                if (m_tlast !== exp_e.last)
                    report_mismatch("last_of_run", 24'(exp_e.last), 24'(m_tlast));
                if (m_tuser[3] !== exp_e.err)
                    report_mismatch("dim_error", 24'(exp_e.err), 24'(m_tuser[3]));
            end
        end
    end

    // Ends a hung run: counts cycles in which neither channel completes a transfer.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_back_to_back();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_sides_idle();
        s_tvalid <= 1'b0;
        while (expected_subentities.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
